@@ rtl/core/pawh_pkg.sv @@
package pawh_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int SUM_BITS       = 64;

    typedef logic signed [SUM_BITS-1:0] t_sum;

    localparam t_sum SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam t_sum SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    typedef struct packed {
        t_sum sum;
        logic ovf;
    } t_sat;

    // vertex control bits that ride along with every pipeline stage
    typedef struct packed {
        logic close;
        logic plast;
        logic hole;
        logic empty;
    } t_flags;

    typedef struct packed {
        t_sum   t1;     // edge from previous vertex, zero on a contour's first vertex
        t_sum   t2;     // closing edge back to the first vertex, zero unless closing
        logic   first;
        t_flags flags;
    } t_term_item;

    typedef struct packed {
        t_sum   csum;   // complete contour sum, valid on closing vertices
        logic   ovf;    // any clamp so far in this contour
        t_flags flags;
    } t_close_item;

    function automatic t_sat sat_add(input t_sum a, input t_sum b);
        t_sat r;
        t_sum s;
        s     = a + b;
        r.ovf = (a[SUM_BITS-1] == b[SUM_BITS-1]) && (s[SUM_BITS-1] != a[SUM_BITS-1]);
        r.sum = r.ovf ? (a[SUM_BITS-1] ? SUM_MIN : SUM_MAX) : s;
        return r;
    endfunction

endpackage

@@ rtl/core/pawh_vert_if.sv @@
interface pawh_vert_if #(
    parameter int COORD_BITS = pawh_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vert_x;
    logic signed [COORD_BITS-1:0] vert_y;
    logic                         is_hole;
    logic                         contour_last;
    logic                         polygon_last;
    logic                         empty_polygon;

    modport source (
        output valid, vert_x, vert_y, is_hole, contour_last, polygon_last, empty_polygon,
        input  ready
    );
    modport sink (
        input  valid, vert_x, vert_y, is_hole, contour_last, polygon_last, empty_polygon,
        output ready
    );
endinterface

@@ rtl/core/pawh_area_if.sv @@
interface pawh_area_if;
    logic               valid;
    logic               ready;
    pawh_pkg::t_sum     area_value;
    logic               is_empty;
    logic               saturated;

    modport source (
        output valid, area_value, is_empty, saturated,
        input  ready
    );
    modport sink (
        input  valid, area_value, is_empty, saturated,
        output ready
    );
endinterface

@@ rtl/core/pawh_front.sv @@
module pawh_front #(
    parameter int COORD_BITS = pawh_pkg::COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pawh_vert_if.sink            i_vert,
    output logic                 o_valid,
    output pawh_pkg::t_term_item o_item,
    input  logic                 i_ready
);
    localparam int EXT_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * EXT_BITS;

    // contour tracking
    logic                         r_mid;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;

    // stage 1: registered vertex with its neighbors
    logic                         r1_valid;
    logic signed [COORD_BITS-1:0] r1_x, r1_y, r1_px, r1_py, r1_fx, r1_fy;
    logic                         r1_first;
    pawh_pkg::t_flags             r1_flags;

    // stage 2: edge products
    logic                         r2_valid;
    pawh_pkg::t_term_item         r2_item;

    logic                         rdy1, rdy2, in_fire, move12;
    logic                         close_in;
    logic signed [EXT_BITS-1:0]   ys1, xd1, ys2, xd2;
    logic signed [PROD_BITS-1:0]  p1, p2;

    assign rdy2     = !r2_valid || i_ready;
    assign rdy1     = !r1_valid || rdy2;
    assign in_fire  = i_vert.valid && rdy1;
    assign move12   = r1_valid && rdy2;
    assign close_in = i_vert.contour_last || i_vert.polygon_last;

    assign i_vert.ready = rdy1;

    assign ys1 = EXT_BITS'(r1_py) + EXT_BITS'(r1_y);
    assign xd1 = EXT_BITS'(r1_px) - EXT_BITS'(r1_x);
    assign ys2 = EXT_BITS'(r1_y) + EXT_BITS'(r1_fy);
    assign xd2 = EXT_BITS'(r1_x) - EXT_BITS'(r1_fx);
    assign p1  = ys1 * xd1;
    assign p2  = ys2 * xd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid    <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r1_valid <= 1'b1;
            end else if (move12) begin
                r1_valid <= 1'b0;
            end
            if (move12) begin
                r2_valid <= 1'b1;
            end else if (i_ready) begin
                r2_valid <= 1'b0;
            end
            if (in_fire) begin
                if (i_vert.empty_polygon) begin
                    r_mid <= 1'b0;
                end else begin
                    r_mid <= !close_in;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r1_x           <= i_vert.vert_x;
            r1_y           <= i_vert.vert_y;
            r1_px          <= r_prev_x;
            r1_py          <= r_prev_y;
            r1_fx          <= r_mid ? r_first_x : i_vert.vert_x;
            r1_fy          <= r_mid ? r_first_y : i_vert.vert_y;
            r1_first       <= !r_mid;
            r1_flags.close <= close_in;
            r1_flags.plast <= i_vert.polygon_last;
            r1_flags.hole  <= i_vert.is_hole;
            r1_flags.empty <= i_vert.empty_polygon;
            r_prev_x       <= i_vert.vert_x;
            r_prev_y       <= i_vert.vert_y;
            if (!r_mid) begin
                r_first_x <= i_vert.vert_x;
                r_first_y <= i_vert.vert_y;
            end
        end
        if (move12) begin
            r2_item.t1    <= r1_first ? '0 : pawh_pkg::t_sum'(p1);
            r2_item.t2    <= r1_flags.close ? pawh_pkg::t_sum'(p2) : '0;
            r2_item.first <= r1_first;
            r2_item.flags <= r1_flags;
        end
    end

    assign o_valid = r2_valid;
    assign o_item  = r2_item;

endmodule

@@ rtl/core/pawh_contour.sv @@
module pawh_contour (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  pawh_pkg::t_term_item  i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output pawh_pkg::t_close_item o_item,
    input  logic                  i_ready
);
    // running sum of the open contour
    pawh_pkg::t_sum        r_acc;
    logic                  r_cov;

    // stage 3: sum including the incoming edge
    logic                  r3_valid;
    pawh_pkg::t_sum        r3_acc;
    pawh_pkg::t_sum        r3_t2;
    logic                  r3_cov;
    pawh_pkg::t_flags      r3_flags;

    // stage 4: ring closed
    logic                  r4_valid;
    pawh_pkg::t_close_item r4_item;

    logic                  rdy3, rdy4, in_fire, move34;
    pawh_pkg::t_sum        base;
    logic                  base_ov;
    pawh_pkg::t_sat        sa, sc;

    assign rdy4    = !r4_valid || i_ready;
    assign rdy3    = !r3_valid || rdy4;
    assign in_fire = i_valid && rdy3;
    assign move34  = r3_valid && rdy4;
    assign o_ready = rdy3;

    assign base    = i_item.first ? '0 : r_acc;
    assign base_ov = i_item.first ? 1'b0 : r_cov;
    assign sa      = pawh_pkg::sat_add(base, i_item.t1);
    assign sc      = pawh_pkg::sat_add(r3_acc, r3_t2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r_acc    <= '0;
            r_cov    <= 1'b0;
        end else begin
            if (in_fire) begin
                r3_valid <= 1'b1;
                r_acc    <= sa.sum;
                r_cov    <= base_ov | sa.ovf;
            end else if (move34) begin
                r3_valid <= 1'b0;
            end
            if (move34) begin
                r4_valid <= 1'b1;
            end else if (i_ready) begin
                r4_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r3_acc   <= sa.sum;
            r3_cov   <= base_ov | sa.ovf;
            r3_t2    <= i_item.t2;
            r3_flags <= i_item.flags;
        end
        if (move34) begin
            r4_item.csum  <= sc.sum;
            r4_item.ovf   <= r3_cov | sc.ovf;
            r4_item.flags <= r3_flags;
        end
    end

    assign o_valid = r4_valid;
    assign o_item  = r4_item;

endmodule

@@ rtl/core/pawh_total.sv @@
module pawh_total (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  pawh_pkg::t_close_item i_item,
    output logic                  o_ready,
    pawh_area_if.source           o_area
);
    // polygon total
    pawh_pkg::t_sum   r_total;
    logic             r_pov;

    // stage 5: signed contour contribution
    logic             r5_valid;
    pawh_pkg::t_sum   r5_term;
    logic             r5_ovf;
    pawh_pkg::t_flags r5_flags;

    // result register
    logic             r_out_valid;
    pawh_pkg::t_sum   r_area;
    logic             r_empty;
    logic             r_sat;

    logic             produce, out_free, move5, rdy5, in_fire;
    pawh_pkg::t_sum   neg, mag;
    logic             mag_ovf;
    pawh_pkg::t_sat   ta;
    logic             pov_new;

    assign produce  = r5_flags.empty || r5_flags.plast;
    assign out_free = !r_out_valid || o_area.ready;
    assign move5    = r5_valid && (!produce || out_free);
    assign rdy5     = !r5_valid || (!produce || out_free);
    assign in_fire  = i_valid && rdy5;
    assign o_ready  = rdy5;

    // magnitude; the most negative sum clamps to the most positive value
    assign neg     = -i_item.csum;
    assign mag_ovf = (i_item.csum == pawh_pkg::SUM_MIN);
    assign mag     = !i_item.csum[pawh_pkg::SUM_BITS-1] ? i_item.csum :
                     (mag_ovf ? pawh_pkg::SUM_MAX : neg);

    assign ta      = pawh_pkg::sat_add(r_total, r5_term);
    assign pov_new = r_pov | r5_ovf | ta.ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_pov       <= 1'b0;
        end else begin
            if (in_fire) begin
                r5_valid <= 1'b1;
            end else if (move5) begin
                r5_valid <= 1'b0;
            end
            if (move5 && produce) begin
                r_out_valid <= 1'b1;
            end else if (o_area.ready) begin
                r_out_valid <= 1'b0;
            end
            if (move5) begin
                if (r5_flags.empty || r5_flags.plast) begin
                    r_total <= '0;
                    r_pov   <= 1'b0;
                end else if (r5_flags.close) begin
                    r_total <= ta.sum;
                    r_pov   <= pov_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r5_term  <= i_item.flags.hole ? -mag : mag;
            r5_ovf   <= i_item.ovf | (mag_ovf & i_item.csum[pawh_pkg::SUM_BITS-1]);
            r5_flags <= i_item.flags;
        end
        if (move5 && produce) begin
            if (r5_flags.empty) begin
                r_area  <= '0;
                r_empty <= 1'b1;
                r_sat   <= 1'b0;
            end else begin
                r_area  <= ta.sum;
                r_empty <= 1'b0;
                r_sat   <= pov_new;
            end
        end
    end

    assign o_area.valid      = r_out_valid;
    assign o_area.area_value = r_area;
    assign o_area.is_empty   = r_empty;
    assign o_area.saturated  = r_sat;

endmodule

@@ rtl/core/polygon_area_with_holes_core.sv @@
// Shoelace area of polygons with holes, one vertex per transaction.
// i_vert carries vertices contour by contour; contour_last marks the last
// vertex of a contour, polygon_last the last vertex of the polygon (it also
// closes an open contour). A transaction with empty_polygon set drops any
// partial polygon and yields an empty result.
// o_area carries one transaction per polygon: the area with one fraction
// bit (halving folded into the binary point), clamped to the signed
// 64-bit range with saturated set when any clamp occurred.
// Throughput: one vertex per cycle while o_area accepts results. The last
// vertex passes through the input register, product register, contour
// accumulate, ring close and signed contribution stages, then the
// result register where the polygon total is added.
// Reset clears all stages, the open contour and the running total; ready
// is already high from the first clock edge under reset.
// When o_area stalls the result register holds; vertices keep flowing until
// a result-producing transaction waits in the signed-contribution stage and
// the four stages behind it fill, then ready drops.
module polygon_area_with_holes_core #(
    parameter int COORD_BITS = pawh_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pawh_vert_if.sink   i_vert,
    pawh_area_if.source o_area
);
    logic                  term_valid, term_ready;
    pawh_pkg::t_term_item  term_item;
    logic                  close_valid, close_ready;
    pawh_pkg::t_close_item close_item;

    pawh_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vert  (i_vert),
        .o_valid (term_valid),
        .o_item  (term_item),
        .i_ready (term_ready)
    );

    pawh_contour u_contour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (term_valid),
        .i_item  (term_item),
        .o_ready (term_ready),
        .o_valid (close_valid),
        .o_item  (close_item),
        .i_ready (close_ready)
    );

    pawh_total u_total (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (close_valid),
        .i_item  (close_item),
        .o_ready (close_ready),
        .o_area  (o_area)
    );

endmodule

@@ rtl/core/pawh_checker.sv @@
module pawh_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input pawh_pkg::t_sum i_area_value,
    input logic           i_is_empty,
    input logic           i_saturated
);
    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // pipeline is empty after reset, so vertices are taken at once
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // an empty polygon reports zero area and no clamp
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_empty |-> (i_area_value == '0) && !i_saturated)
        else $error("empty result carries area or saturation");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_area_value) && $stable(i_is_empty)
            && $stable(i_saturated))
        else $error("stalled result changed");

endmodule

bind polygon_area_with_holes_core pawh_checker u_pawh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_vert.ready),
    .i_out_valid  (o_area.valid),
    .i_out_ready  (o_area.ready),
    .i_area_value (o_area.area_value),
    .i_is_empty   (o_area.is_empty),
    .i_saturated  (o_area.saturated)
);
